// ===== rtl/lts8_pkg.sv =====
// Shared types, constants and the sRGB half-code threshold table for the
// linear-to-sRGB pixel mapper. No dependencies.
`default_nettype none

package lts8_pkg;

	// Restoring divider: one integer bit and 66 fraction bits of pm/alpha.
	localparam int DIV_BITS   = 67;
	localparam int QF_W       = DIV_BITS - 1;
	localparam int SRCH_STEPS = 8;
	localparam int NUM_THR    = 255;
	// Classify stage, divider stages, align stage, search stages.
	localparam int LANE_LAT   = 1 + DIV_BITS + 1 + SRCH_STEPS;
	localparam int PIPE_LAT   = LANE_LAT + 1;

	typedef enum logic [1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_WIDTH    = 2'd2,
		REG_HEIGHT   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [31:0]        red_word;
		logic [31:0]        green_word;
		logic [31:0]        blue_word;
		logic [31:0]        alpha_word;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red_byte;
		logic [7:0] green_byte;
		logic [7:0] blue_byte;
		logic [7:0] alpha_byte;
	} result_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic [15:0]        width;
		logic [15:0]        height;
	} window_t;

	typedef struct packed {
		logic       kill;
		logic [7:0] alpha_byte;
	} side_t;

	// Each entry: {shift nibble, 52-bit fraction}. The threshold is
	// 1.frac * 2^(shift-13).
	localparam logic [55:0] THR_RAW [0:NUM_THR-1] = '{
		56'h0_3e45677c176f7, 56'h1_dd681b3a23272, 56'h2_8dd6c15b1d4b4, 56'h3_167cba8c94818,
		56'h3_660e146b9a5d5, 56'h3_b59f6e4aa0393, 56'h4_02986414d30a8, 56'h4_2a61110455f87,
		56'h4_5229bdf3d8e66, 56'h4_79f26ae35bd45, 56'h4_a1e5a03a8a4b8, 56'h4_cbf734477e0ea,
		56'h4_f8680590912c3, 56'h5_13a0be3e98ad6, 56'h5_2c4665c6bc58d, 56'h5_4629793a399b2,
		56'h5_614e60755415c, 56'h5_7db96ca0c99db, 56'h5_9b6ed95fb6dbe, 56'h5_ba72cde4cb5cb,
		56'h5_dac95df18329c, 56'h5_fc768ac1bd734, 56'h6_0fbf21f2dc48c, 56'h6_21f234061c55c,
		56'h6_34d662df32dde, 56'h6_486d8e075e9d7, 56'h6_5cb98d9e25461, 56'h6_71bc32a59ad48,
		56'h6_87774749cc7c7, 56'h6_9dec8f23ba5c1, 56'h6_b51dc7783fa2c, 56'h6_cd0ca7733ec86,
		56'h6_e5bae05f5ea9b, 56'h6_ff2a1dda9da48, 56'h7_0cae0303fc81e, 56'h7_1a291cdf30865,
		56'h7_28072a5a9656b, 56'h7_3648f6d71d8d6, 56'h7_44ef4b4ef6b8f, 56'h7_53faee688f618,
		56'h7_636ca4889ebee, 56'h7_73452fe3532a8, 56'h7_8385508caeef9, 56'h7_942dc48821f77,
		56'h7_a53f47d76ca88, 56'h7_b6ba9488d7614, 56'h7_c8a062c4c9087, 56'h7_daf168dac6650,
		56'h7_edae5b4de330e, 56'h8_006bf67056983, 56'h8_0a3767504c7e5, 56'h8_1439d7f87bcfc,
		56'h8_1e739f4abdd1d, 56'h8_28e5135e29dec, 56'h8_338e8983f0649, 56'h8_3e70564c063c4,
		56'h8_498acd89a2d59, 56'h8_54de4257938ce, 56'h8_606b071c66585, 56'h8_6c316d8e6dd5f,
		56'h8_7831c6b7a0a45, 56'h8_846c62f955cee, 56'h8_90e1920fdffcf, 56'h8_9d91a31608f92,
		56'h8_aa7ce4886f088, 56'h8_b7a3a448c57c0, 56'h8_c5062fa0f9c9d, 56'h8_d2a4d3463e6bc,
		56'h8_e07fdb5bfcb10, 56'h8_ee979376ae979, 56'h8_fcec469ea1bea, 56'h9_05bf1fa952341,
		56'h9_0d26e3c54ebea, 56'h9_14ad945d08395, 56'h9_1c5355e946f20, 56'h9_24184ca308d88,
		56'h9_2bfc9c84a7aee, 56'h9_3400694af6b4b, 56'h9_3c23d67658243, 56'h9_4467074bcad41,
		56'h9_4cca1ed5f04cb, 56'h9_554d3fe60b982, 56'h9_5df08d14f9172, 56'h9_66b428c41f9a3,
		56'h9_6f98351e5b03d, 56'h9_789cd418e0ac3, 56'h9_81c227741dc31, 56'h9_8b0850bc8fe6c,
		56'h9_946f714b98254, 56'h9_9df7aa4848999, 56'h9_a7a11ca82cd66, 56'h9_b16be9300d4ba,
		56'h9_bb583074add2f, 56'h9_c56612db878e0, 56'h9_cf95b09b7e3e9, 56'h9_d9e729bd913de,
		56'h9_e45a9e1d883c9, 56'h9_eef02d6a9be77, 56'h9_f9a7f7281a9ad, 56'ha_02410d57049f7,
		56'ha_07bf5b94e038a, 56'ha_0d4ef5cf430b2, 56'ha_12efeb7311b7a, 56'ha_18a24bd8bbe9e,
		56'ha_1e66264484130, 56'ha_243b89e6c58e7, 56'ha_2a2285dc393e7, 56'ha_301b292e38aa5,
		56'ha_362582d2ffac5, 56'ha_3c41a1adecb79, 56'ha_426f948fbfc2a, 56'ha_48af6a36d7de5,
		56'ha_4f01314f6f860, 56'ha_5564f873d7af8, 56'ha_5bdace2cb1a52, 56'ha_6262c0f127b38,
		56'ha_68fcdf2724b0d, 56'ha_6fa937238a690, 56'ha_7667d72a66f40, 56'ha_7d38cd6f28feb,
		56'ha_841c2814d30ef, 56'ha_8b11f52e2dc70, 56'ha_921a42bdf9328, 56'ha_99351eb71d1fa,
		56'ha_a06296fcd88fe, 56'ha_a7a2b962f040b, 56'ha_aef593addc584, 56'ha_b65b3392f5354,
		56'ha_bdd3a6b89f6da, 56'ha_c55efab676fe7, 56'ha_ccfd3d1579b04, 56'ha_d4ae7b5030bad,
		56'ha_dc72c2d2d9a61, 56'ha_e44a20fb8e727, 56'ha_ec34a31a6d0ba, 56'ha_f4325671be06c,
		56'ha_fc4348361ab77, 56'hb_0233c2c7494c2, 56'hb_064f8dca68079, 56'hb_0a750baa9e48f,
		56'hb_0ea442e792158, 56'hb_12dd39fa6c334, 56'hb_171ff755e9548, 56'hb_1b6c81666af88,
		56'hb_1fc2de920806b, 56'hb_242315389d222, 56'hb_288d2bb3dcb8f, 56'hb_2d0128575ed21,
		56'hb_317f1170b096f, 56'hb_3606ed4763a0b, 56'hb_3a98c21d1d042, 56'hb_3f34962da4214,
		56'hb_43da6faef137f, 56'hb_488a54d13bc08, 56'hb_4d444bbf088ca, 56'hb_52085a9d37af8,
		56'hb_56d6878b122da, 56'hb_5baed8a2577ae, 56'hb_609153f74abf7, 56'hb_657dff98bfed0,
		56'hb_6a74e190289f5, 56'hb_6f75ffe1a0cbd, 56'hb_7481608bfb427, 56'hb_79970988cdfce,
		56'hb_7eb700cc7e40e, 56'hb_83e14c464c95a, 56'hb_8915f1e0608a5, 56'hb_8e54f77fd4546,
		56'hb_939e6304c03f7, 56'hb_98f23a4a45f6d, 56'hb_9e5083269ba34, 56'hb_a3b9436b16e19,
		56'hb_a92c80e43791b, 56'hb_aeaa4159b27fb, 56'hb_b4328a8e7be4c, 56'hb_b9c56240d1c5d,
		56'hb_bf62ce2a462aa, 56'hb_c50ad3ffc933b, 56'hb_cabd7971b30b6, 56'hb_d07ac42bcdb4a,
		56'hb_d642b9d55eb89, 56'hb_dc15601130b24, 56'hb_e1f2bc7d9cba7, 56'hb_e7dad4b493b2a,
		56'hb_edcdae4ba7709, 56'hb_f3cb4ed413cc2, 56'hb_f9d3bbdac78d3, 56'hb_ffe6fae86d3d9,
		56'hc_030288c0b9ede, 56'hc_061702930bb95, 56'hc_0930eda934ca4, 56'hc_0c504cbf2cdcb,
		56'hc_0f75228edec23, 56'hc_129f71d02c75d, 56'hc_15cf3d38f323e, 56'hc_1904877d0f24e,
		56'hc_1c3f534e5fea6, 56'hc_1f7fa35ccbe1d, 56'hc_22c57a564448d, 56'hc_2610dae6c8f66,
		56'hc_2961c7b86c18a, 56'hc_2cb8437355e5c, 56'hc_301450bdc8433, 56'hc_3375f23c225fe,
		56'hc_36dd2a90e443e, 56'hc_3a49fc5cb2567, 56'hc_3dbc6a3e58d7b, 56'hc_413476d2cf4ff,
		56'hc_44b224b53bf63, 56'hc_4835767ef70a3, 56'hc_4bbe6ec78e26b, 56'hc_4f4d1024c7885,
		56'hc_52e15d2aa54a8, 56'hc_567b586b689d0, 56'hc_5a1b047794ed6, 56'hc_5dc063ddf3091,
		56'hc_616b792b94359, 56'hc_651c46ebd53f5, 56'hc_68d2cfa861812, 56'hc_6c8f15e935e12,
		56'hc_70511c34a3c68, 56'hc_7418e50f5406a, 56'hc_77e672fc49c8e, 56'hc_7bb9c87ce563f,
		56'hc_7f92e810e7317, 56'hc_8371d436725ac, 56'hc_87568f6a0f9dd, 56'hc_8b411c26b009b,
		56'hc_8f317ce5afb41, 56'hc_9327b41ed8677, 56'hc_9723c44864499, 56'hc_9b25afd7007b1,
		56'hc_9f2d793dcfaf0, 56'hc_a33b22ee6cbcf, 56'hc_a74eaf58ed2a6, 56'hc_ab6820ebe3af4,
		56'hc_af877a1462b19, 56'hc_b3acbd3dfebc1, 56'hc_b7d7ecd2d0ee1, 56'hc_bc090b3b79646,
		56'hc_c0401adf219b9, 56'hc_c47d1e237ecd4, 56'hc_c8c0176cd4465, 56'hc_cd09091df5b72,
		56'hc_d157f598497d5, 56'hc_d5acdf3bcae8c, 56'hc_da07c8670c7a9, 56'hc_de68b3773a1c8,
		56'hc_e2cfa2c81b55a, 56'hc_e73c98b41576f, 56'hc_ebaf97942dc34, 56'hc_f028a1c00b92b,
		56'hc_f4a7b98dfa6ec, 56'hc_f92ce152ec2b6, 56'hc_fdb81b627af91
	};

	// Midpoint between a threshold and the double just below it, as a
	// fixed-point fraction with QF_W bits. A double quotient rounds to at
	// least the threshold exactly when the true quotient reaches this point.
	function automatic logic [QF_W-1:0] thr_mid(input logic [7:0] idx);
		logic [55:0] raw;
		logic [53:0] odd;
		logic [QF_W-1:0] wide;
		raw = THR_RAW[idx];
		odd = {1'b1, raw[51:0], 1'b0} - 54'd1;
		wide = {{(QF_W-54){1'b0}}, odd};
		thr_mid = wide << raw[55:52];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/linear_to_srgb8_pixel_mapper_top.sv =====
// Top level of the linear-to-sRGB 8-bit pixel mapper: configuration
// registers, valid pipeline, three color lanes, side path and merge.
// Depends on lts8_pkg, lts8_lane, lts8_side, lts8_merge.
//
//  channel   signals                               transfer when
//  ------    -------------------------------       ----------------------
//  pixel     start, busy, pixel                    start && !busy
//  config    cfg_valid, cfg_ready, cfg_index,      cfg_valid && cfg_ready
//            cfg_data
//  result    done, result                          every cycle done is high
//
// One pixel enters per clock; busy stays low, so start may be held high.
// Each result follows its pixel transfer through one classify
// stage, 67 divider stages (one quotient bit each), one align stage, eight
// table search stages and the merge register.
// Reset clears the configuration registers and the valid pipeline; no
// pixel in flight at reset produces a result.
// The receiver cannot stall; done is high for exactly one cycle per result.
`default_nettype none

module linear_to_srgb8_pixel_mapper_top import lts8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pixel_t      pixel,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output result_t     result
);

	window_t win_q;
	logic    accept;
	logic [LANE_LAT-1:0] vld_q;
	logic [7:0] red_code, green_code, blue_code;
	side_t   side;

	// no stall source inside: the pipeline always advances
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	// register writes; each pixel samples the window as it enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X: win_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: win_q.origin_y <= cfg_data;
				REG_WIDTH:    win_q.width <= cfg_data[15:0];
				REG_HEIGHT:   win_q.height <= cfg_data[15:0];
				default:      win_q <= win_q;
			endcase
		end
	end

	// advance the valid marks alongside the lane payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LANE_LAT-2:0], accept};
		end
	end

	lts8_lane u_red (
		.clk     (clk),
		.pm_word (pixel.red_word),
		.a_word  (pixel.alpha_word),
		.code    (red_code)
	);

	lts8_lane u_green (
		.clk     (clk),
		.pm_word (pixel.green_word),
		.a_word  (pixel.alpha_word),
		.code    (green_code)
	);

	lts8_lane u_blue (
		.clk     (clk),
		.pm_word (pixel.blue_word),
		.a_word  (pixel.alpha_word),
		.code    (blue_code)
	);

	lts8_side u_side (
		.clk   (clk),
		.pixel (pixel),
		.win   (win_q),
		.side  (side)
	);

	lts8_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld        (vld_q[LANE_LAT-1]),
		.red_code   (red_code),
		.green_code (green_code),
		.blue_code  (blue_code),
		.side       (side),
		.done       (done),
		.result     (result)
	);

endmodule

`default_nettype wire

// ===== rtl/lts8_lane.sv =====
// One color lane: classify, restoring divide of channel by alpha, align,
// then binary search of the threshold table. Depends on lts8_pkg.
`default_nettype none

module lts8_lane import lts8_pkg::*; (
	input  logic        clk,
	input  logic [31:0] pm_word,
	input  logic [31:0] a_word,
	output logic [7:0]  code
);

	function automatic logic [4:0] lead_zeros(input logic [23:0] m);
		logic [4:0] n;
		logic found;
		n = 5'd0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && m[i]) begin
				n = 5'(23 - i);
				found = 1'b1;
			end
		end
		lead_zeros = n;
	endfunction

	logic [7:0]  p_exp, a_exp;
	logic        p_nan, a_nan, force0, force255, far;
	logic [23:0] p_mant, a_mant, p_norm, a_norm;
	logic [4:0]  p_lz, a_lz;
	logic signed [9:0] p_e, a_e, e_diff;

	always_comb begin
		p_exp = pm_word[30:23];
		a_exp = a_word[30:23];
		p_nan = (p_exp == 8'hFF) && (pm_word[22:0] != 23'd0);
		a_nan = (a_exp == 8'hFF) && (a_word[22:0] != 23'd0);
		force0 = !p_nan && (pm_word[31] || pm_word[30:0] == 31'd0);
		force255 = !force0 && (p_nan || a_nan || a_word[31] ||
			(pm_word[30:0] >= a_word[30:0]));
		p_mant = (p_exp == 8'd0) ? {1'b0, pm_word[22:0]} : {1'b1, pm_word[22:0]};
		a_mant = (a_exp == 8'd0) ? {1'b0, a_word[22:0]} : {1'b1, a_word[22:0]};
		p_lz = lead_zeros(p_mant);
		a_lz = lead_zeros(a_mant);
		p_norm = p_mant << p_lz;
		a_norm = a_mant << a_lz;
		p_e = $signed({2'b00, (p_exp == 8'd0) ? 8'd1 : p_exp}) - $signed({5'd0, p_lz});
		a_e = $signed({2'b00, (a_exp == 8'd0) ? 8'd1 : a_exp}) - $signed({5'd0, a_lz});
		e_diff = a_e - p_e;
		// infinite alpha, or a quotient below the finest grid step: code 0
		far = (a_exp == 8'hFF) || (e_diff > $signed(10'(QF_W)));
	end

	logic [24:0]          dv_rem_s [0:DIV_BITS];
	logic [23:0]          dv_ma_s  [0:DIV_BITS];
	logic [DIV_BITS-1:0]  dv_q_s   [0:DIV_BITS];
	logic [6:0]           dv_sh_s  [0:DIV_BITS];
	logic                 dv_f0_s  [0:DIV_BITS];
	logic                 dv_ff_s  [0:DIV_BITS];

	always_ff @(posedge clk) begin
		dv_rem_s[0] <= {1'b0, p_norm};
		dv_ma_s[0]  <= a_norm;
		dv_q_s[0]   <= '0;
		dv_sh_s[0]  <= e_diff[6:0];
		dv_f0_s[0]  <= force0 || (!force255 && far);
		dv_ff_s[0]  <= force255;
	end

	for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
		logic [25:0] diff;
		logic        ge;
		assign diff = {1'b0, dv_rem_s[k-1]} - {2'b00, dv_ma_s[k-1]};
		assign ge = !diff[25];
		always_ff @(posedge clk) begin
			dv_rem_s[k] <= ge ? {diff[23:0], 1'b0} : {dv_rem_s[k-1][23:0], 1'b0};
			dv_q_s[k]   <= {dv_q_s[k-1][DIV_BITS-2:0], ge};
			dv_ma_s[k]  <= dv_ma_s[k-1];
			dv_sh_s[k]  <= dv_sh_s[k-1];
			dv_f0_s[k]  <= dv_f0_s[k-1];
			dv_ff_s[k]  <= dv_ff_s[k-1];
		end
	end

	logic [QF_W-1:0] sr_q_s   [0:SRCH_STEPS];
	logic [7:0]      sr_cnt_s [0:SRCH_STEPS];
	logic            sr_f0_s  [0:SRCH_STEPS];
	logic            sr_ff_s  [0:SRCH_STEPS];
	logic [DIV_BITS-1:0] q_shr;

	// align the quotient to the threshold grid
	assign q_shr = dv_q_s[DIV_BITS] >> dv_sh_s[DIV_BITS];

	always_ff @(posedge clk) begin
		sr_q_s[0]   <= q_shr[QF_W-1:0];
		sr_cnt_s[0] <= 8'd0;
		sr_f0_s[0]  <= dv_f0_s[DIV_BITS];
		sr_ff_s[0]  <= dv_ff_s[DIV_BITS];
	end

	for (genvar j = 1; j <= SRCH_STEPS; j++) begin : g_srch
		logic [7:0] probe;
		logic       hit;
		assign probe = sr_cnt_s[j-1] | (8'd1 << (SRCH_STEPS - j));
		assign hit = thr_mid(probe - 8'd1) <= sr_q_s[j-1];
		always_ff @(posedge clk) begin
			sr_cnt_s[j] <= hit ? probe : sr_cnt_s[j-1];
			sr_q_s[j]   <= sr_q_s[j-1];
			sr_f0_s[j]  <= sr_f0_s[j-1];
			sr_ff_s[j]  <= sr_ff_s[j-1];
		end
	end

	assign code = sr_f0_s[SRCH_STEPS] ? 8'd0 :
		(sr_ff_s[SRCH_STEPS] ? 8'hFF : sr_cnt_s[SRCH_STEPS]);

endmodule

`default_nettype wire

// ===== rtl/lts8_side.sv =====
// Window test, transparency test and alpha quantizer, delayed to line up
// with the color lanes. Depends on lts8_pkg.
`default_nettype none

module lts8_side import lts8_pkg::*; (
	input  logic    clk,
	input  pixel_t  pixel,
	input  window_t win,
	output side_t   side
);

	logic signed [33:0] px, py, lim_x, lim_y;
	logic        in_win;
	logic [7:0]  a_exp;
	logic [31:0] prod, t_val;
	logic [7:0]  sh;
	logic [9:0]  n_val;
	logic [7:0]  a_byte;

	always_comb begin
		px = 34'(pixel.pos_x);
		py = 34'(pixel.pos_y);
		lim_x = 34'(win.origin_x) + $signed({18'd0, win.width});
		lim_y = 34'(win.origin_y) + $signed({18'd0, win.height});
		in_win = (px >= 34'(win.origin_x)) && (px < lim_x) &&
			(py >= 34'(win.origin_y)) && (py < lim_y);

		a_exp = pixel.alpha_word[30:23];
		prod = {8'd0, 1'b1, pixel.alpha_word[22:0]} * 32'd255;
		sh = 8'd149 - a_exp;
		t_val = prod >> sh[5:0];
		n_val = (t_val[9:0] + 10'd1) >> 1;
		if (pixel.alpha_word[31] || a_exp < 8'd117) begin
			a_byte = 8'd0;
		end else if (a_exp == 8'hFF && pixel.alpha_word[22:0] != 23'd0) begin
			a_byte = 8'd0;
		end else if (a_exp >= 8'd127 || n_val >= 10'd255) begin
			a_byte = 8'hFF;
		end else begin
			a_byte = n_val[7:0];
		end
	end

	side_t sd_s [0:LANE_LAT-1];

	always_ff @(posedge clk) begin
		sd_s[0].kill       <= !in_win || (pixel.alpha_word[30:0] == 31'd0);
		sd_s[0].alpha_byte <= a_byte;
	end

	for (genvar i = 1; i < LANE_LAT; i++) begin : g_dly
		always_ff @(posedge clk) begin
			sd_s[i] <= sd_s[i-1];
		end
	end

	assign side = sd_s[LANE_LAT-1];

endmodule

`default_nettype wire

// ===== rtl/lts8_merge.sv =====
// Merging stage: combines the three lane codes and the alpha path into
// the result register and drives the strobe. Depends on lts8_pkg.
`default_nettype none

module lts8_merge import lts8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  logic [7:0] red_code,
	input  logic [7:0] green_code,
	input  logic [7:0] blue_code,
	input  side_t      side,
	output logic       done,
	output result_t    result
);

	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (side.kill) begin
			result_q <= '0;
		end else begin
			result_q <= '{red_byte: red_code, green_byte: green_code,
				blue_byte: blue_code, alpha_byte: side.alpha_byte};
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/lts8_checker.sv =====
// Port-level checker for the pixel mapper and its bind to the top level.
// Depends on lts8_pkg.
`default_nettype none

module lts8_checker import lts8_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input pixel_t  pixel,
	input logic    done,
	input result_t result
);

	logic [6:0] warm_cnt_q;
	logic       warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cnt_q <= 7'd0;
		end else if (warm_cnt_q != 7'(PIPE_LAT)) begin
			warm_cnt_q <= warm_cnt_q + 7'd1;
		end
	end

	assign warm = (warm_cnt_q == 7'(PIPE_LAT));

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, PIPE_LAT)))
		else $error("result strobe does not follow pixel transfer");

	a_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(pixel.alpha_word[30:0] == 31'd0, PIPE_LAT))
		|-> (result == '0))
		else $error("zero alpha pixel gave nonzero result");

	a_neg_red: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(pixel.red_word[31] &&
		(pixel.red_word[30:23] != 8'hFF), PIPE_LAT)) |-> (result.red_byte == 8'd0))
		else $error("negative red gave nonzero code");

endmodule

bind linear_to_srgb8_pixel_mapper_top lts8_checker u_lts8_checker (.*);

`default_nettype wire
